/* src/bnms_pkg.sv */
// ----------------------------------------------------------------------------
// bnms_pkg
// Shared types and constants for the box non-maximum suppression block.
// ----------------------------------------------------------------------------
package bnms_pkg;

  localparam int unsigned CoordBits = 14;
  localparam int unsigned DimBits   = 13;
  localparam int unsigned ScoreBits = 16;
  localparam int unsigned IdxBits   = 6;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgDataBits = 17;
  localparam logic [16:0] OneQ16  = 17'd65536;
  localparam logic [15:0] HalfQ16 = 16'd32768;
  localparam logic [15:0] OverlapThrReset = 16'd29491;
  localparam int unsigned ResultCap = 64;

  typedef enum logic [1:0] {
    CFG_SCORE_THR   = 2'd0,
    CFG_OVERLAP_THR = 2'd1,
    CFG_DECAY       = 2'd2,
    CFG_KEEP_TOP    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [IdxBits-1:0] keep_idx;
    logic               none_kept;
    logic               dropped_overflow;
    logic               result_last;
  } result_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FILT_RD,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_TRIM,
    ST_CAND_RD,
    ST_CAND_BOX,
    ST_IOU_RD,
    ST_IOU_BOX,
    ST_IOU_A,
    ST_IOU_B,
    ST_IOU_C,
    ST_EMIT_RD,
    ST_EMIT
  } state_e;

endpackage

/* src/bnms_if.sv */
// ----------------------------------------------------------------------------
// bnms_box_if / bnms_res_if / bnms_cfg_if
// Valid/ready channels for boxes, results and register writes.
// ----------------------------------------------------------------------------
interface bnms_box_if;
  logic                               valid;
  logic                               ready;
  logic signed [bnms_pkg::CoordBits-1:0] box_left;
  logic signed [bnms_pkg::CoordBits-1:0] box_top;
  logic [bnms_pkg::DimBits-1:0]       box_width;
  logic [bnms_pkg::DimBits-1:0]       box_height;
  logic [bnms_pkg::ScoreBits-1:0]     box_score;
  logic                               box_last;
  modport source (output valid, box_left, box_top, box_width, box_height, box_score,
                  box_last, input ready);
  modport sink (input valid, box_left, box_top, box_width, box_height, box_score,
                box_last, output ready);
endinterface

interface bnms_res_if;
  logic                          valid;
  logic                          ready;
  logic [bnms_pkg::IdxBits-1:0]  keep_idx;
  logic                          none_kept;
  logic                          dropped_overflow;
  logic                          result_last;
  modport source (output valid, keep_idx, none_kept, dropped_overflow, result_last,
                  input ready);
  modport sink (input valid, keep_idx, none_kept, dropped_overflow, result_last,
                output ready);
endinterface

interface bnms_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bnms_pkg::CfgIdxBits-1:0]   index;
  logic [bnms_pkg::CfgDataBits-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/bnms_iou.sv */
// ----------------------------------------------------------------------------
// bnms_iou
// Three-stage IoU suppression test: geometry, products, threshold compare.
// ----------------------------------------------------------------------------
module bnms_iou (
  input  logic                                clk_i,
  input  logic signed [bnms_pkg::CoordBits-1:0] a_left_i,
  input  logic signed [bnms_pkg::CoordBits-1:0] a_top_i,
  input  logic [bnms_pkg::DimBits-1:0]        a_w_i,
  input  logic [bnms_pkg::DimBits-1:0]        a_h_i,
  input  logic signed [bnms_pkg::CoordBits-1:0] b_left_i,
  input  logic signed [bnms_pkg::CoordBits-1:0] b_top_i,
  input  logic [bnms_pkg::DimBits-1:0]        b_w_i,
  input  logic [bnms_pkg::DimBits-1:0]        b_h_i,
  input  logic [15:0]                         thr_i,
  output logic                                suppress_o
);
  import bnms_pkg::*;

  localparam int unsigned EB = CoordBits + 1;

  logic signed [EB-1:0] l, t, r, b;
  logic signed [EB:0]   dw, dh;
  logic [DimBits:0] iw_d, ih_d, iw_q, ih_q;
  logic [DimBits-1:0] aw_q, ah_q, bw_q, bh_q;
  logic [2*DimBits+1:0] inter_q, aa_q, ab_q;
  logic [15:0] thr1_q, thr2_q;
  logic [2*DimBits+2:0] uni;
  logic [2*DimBits+17:0] lhs, rhs;

  always_comb begin
    l = (a_left_i > b_left_i) ? EB'(a_left_i) : EB'(b_left_i);
    t = (a_top_i > b_top_i) ? EB'(a_top_i) : EB'(b_top_i);
    r = ($signed(EB'(a_left_i)) + $signed({2'b0, a_w_i}) <
         $signed(EB'(b_left_i)) + $signed({2'b0, b_w_i})) ?
        EB'($signed(EB'(a_left_i)) + $signed({2'b0, a_w_i})) :
        EB'($signed(EB'(b_left_i)) + $signed({2'b0, b_w_i}));
    b = ($signed(EB'(a_top_i)) + $signed({2'b0, a_h_i}) <
         $signed(EB'(b_top_i)) + $signed({2'b0, b_h_i})) ?
        EB'($signed(EB'(a_top_i)) + $signed({2'b0, a_h_i})) :
        EB'($signed(EB'(b_top_i)) + $signed({2'b0, b_h_i}));
    dw = $signed({r[EB-1], r}) - $signed({l[EB-1], l});
    dh = $signed({b[EB-1], b}) - $signed({t[EB-1], t});
    iw_d = (dw > 0) ? dw[DimBits:0] : '0;
    ih_d = (dh > 0) ? dh[DimBits:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    iw_q <= iw_d;  ih_q <= ih_d;
    aw_q <= a_w_i; ah_q <= a_h_i; bw_q <= b_w_i; bh_q <= b_h_i;
    thr1_q <= thr_i;
    inter_q <= (2*DimBits+2)'(iw_q * ih_q);
    aa_q <= (2*DimBits+2)'(aw_q * ah_q);
    ab_q <= (2*DimBits+2)'(bw_q * bh_q);
    thr2_q <= thr1_q;
  end

  always_comb begin
    uni = (2*DimBits+3)'(aa_q) + (2*DimBits+3)'(ab_q) - (2*DimBits+3)'(inter_q);
    lhs = {inter_q, 16'b0};
    rhs = (2*DimBits+18)'(thr2_q * uni[2*DimBits+1:0]);
    suppress_o = (inter_q != '0) && (lhs > rhs);
  end
endmodule

/* src/box_non_maximum_suppression_top.sv */
// ----------------------------------------------------------------------------
// box_non_maximum_suppression_top
// Greedy score-sorted non-maximum suppression over a set of up to MAX_BOXES.
// ----------------------------------------------------------------------------
// Boxes enter on box_in, one transaction per cycle while the block is loading.
// The transaction with box_last set closes the set. Filtering then reads each
// box's score, skips boxes at or below the score threshold and inserts each
// candidate into the order memory, shifting lower-scored entries up. The
// greedy pass tests each candidate against every kept box in turn (single
// memory read port plus the three-stage IoU unit) and keeps it when none
// suppresses it. Kept indices leave on res_out, one transaction per kept
// index, each after a read of the kept memory, result_last on the final one;
// an empty run gives a single transaction with none_kept set. box_in is not
// ready during a run. Boxes past MAX_BOXES are discarded and reported through
// dropped_overflow. A stalled receiver holds the result register and the
// sequencer. Reset returns the registers to their defaults and empties the
// set; memories need no clearing. cfg_in is always ready.
// ----------------------------------------------------------------------------
module box_non_maximum_suppression_top #(
  parameter int unsigned MAX_BOXES  = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  bnms_box_if.sink   box_in,
  bnms_cfg_if.sink   cfg_in,
  bnms_res_if.source res_out
);
  import bnms_pkg::*;

  localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam int unsigned KW = $clog2(ResultCap + 1);
  localparam int unsigned BW = 2*CoordBits + 2*DimBits;
  localparam int unsigned OW = ScoreBits + AW;

  // registers
  logic [15:0] score_thr_q, ovl_thr_q;
  logic [16:0] decay_q;
  logic [6:0]  keep_top_q;

  // memories; order entries carry the score so the sort needs one read
  logic [BW-1:0]        box_mem [MAX_BOXES];
  logic [ScoreBits-1:0] score_mem [MAX_BOXES];
  logic [OW-1:0]        order_mem [MAX_BOXES];
  logic [AW-1:0]        kept_mem [ResultCap];

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, cand_q, cand_d;
  logic [KW-1:0] kept_q, kept_d, k_q, k_d;
  logic ovf_q, ovf_d;
  logic [15:0] cur_thr_q, cur_thr_d;
  logic [ScoreBits-1:0] cur_score_q, cur_score_d;
  logic [AW-1:0] cur_idx_q, cur_idx_d;

  // memory ports
  logic box_we, ord_we, kept_we;
  logic [AW-1:0] box_ra, sc_ra, ord_wa, ord_ra;
  logic [OW-1:0] ord_wd;
  logic [KW-2:0] kept_ra;
  logic [BW-1:0] box_rd, cand_box_q;
  logic [ScoreBits-1:0] sc_rd;
  logic [OW-1:0] ord_rd;
  logic [AW-1:0] kept_rd;

  logic res_valid_q, res_valid_d;
  result_t res_q, res_d;
  logic cand_box_ld;
  logic suppress;
  logic [32:0] dec_prod;

  assign cfg_in.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_thr_q <= '0;
      ovl_thr_q   <= OverlapThrReset;
      decay_q     <= OneQ16;
      keep_top_q  <= '0;
    end else if (cfg_in.valid) begin
      case (cfg_idx_e'(cfg_in.index))
        CFG_SCORE_THR:   score_thr_q <= cfg_in.data[15:0];
        CFG_OVERLAP_THR: ovl_thr_q   <= cfg_in.data[15:0];
        CFG_DECAY:       decay_q     <= cfg_in.data;
        CFG_KEEP_TOP:    keep_top_q  <= cfg_in.data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (box_we) begin
      box_mem[cnt_q[AW-1:0]]   <= {box_in.box_left, box_in.box_top, box_in.box_width,
                                   box_in.box_height};
      score_mem[cnt_q[AW-1:0]] <= box_in.box_score;
    end
    if (ord_we) order_mem[ord_wa] <= ord_wd;
    if (kept_we) kept_mem[(KW-1)'(kept_q)] <= cur_idx_q;
    box_rd  <= box_mem[box_ra];
    sc_rd   <= score_mem[sc_ra];
    ord_rd  <= order_mem[ord_ra];
    kept_rd <= kept_mem[kept_ra];
    if (cand_box_ld) cand_box_q <= box_rd;
  end

  bnms_iou u_iou (
    .clk_i,
    .a_left_i (cand_box_q[BW-1 -: CoordBits]),
    .a_top_i  (cand_box_q[CoordBits+2*DimBits-1 -: CoordBits]),
    .a_w_i    (cand_box_q[2*DimBits-1 -: DimBits]),
    .a_h_i    (cand_box_q[DimBits-1:0]),
    .b_left_i (box_rd[BW-1 -: CoordBits]),
    .b_top_i  (box_rd[CoordBits+2*DimBits-1 -: CoordBits]),
    .b_w_i    (box_rd[2*DimBits-1 -: DimBits]),
    .b_h_i    (box_rd[DimBits-1:0]),
    .thr_i    (cur_thr_q),
    .suppress_o (suppress)
  );

  assign dec_prod = 33'(cur_thr_q) * 33'(decay_q);
  assign box_in.ready = (state_q == ST_LOAD);
  assign res_out.valid = res_valid_q;
  assign res_out.keep_idx = res_q.keep_idx;
  assign res_out.none_kept = res_q.none_kept;
  assign res_out.dropped_overflow = res_q.dropped_overflow;
  assign res_out.result_last = res_q.result_last;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q; cand_d = cand_q;
    kept_d = kept_q; k_d = k_q; ovf_d = ovf_q; cur_thr_d = cur_thr_q;
    cur_score_d = cur_score_q; cur_idx_d = cur_idx_q;
    res_valid_d = res_valid_q; res_d = res_q;
    box_we = 1'b0; ord_we = 1'b0; kept_we = 1'b0; cand_box_ld = 1'b0;
    box_ra = '0; sc_ra = '0; ord_ra = '0; ord_wa = '0; ord_wd = '0; kept_ra = '0;
    if (res_out.ready) res_valid_d = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (box_in.valid) begin
          if (cnt_q < CW'(MAX_BOXES)) begin
            box_we = 1'b1; cnt_d = cnt_q + CW'(1);
          end else ovf_d = 1'b1;
          if (box_in.box_last) begin
            state_d = ST_FILT_RD; i_d = '0; cand_d = '0;
          end
        end
      end
      ST_FILT_RD: begin
        if (i_q == cnt_q) state_d = ST_TRIM;
        else begin
          sc_ra = i_q[AW-1:0]; state_d = ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        cur_score_d = sc_rd; cur_idx_d = i_q[AW-1:0];
        if (sc_rd > score_thr_q) begin
          j_d = cand_q;
          if (cand_q == '0) state_d = ST_INS_PUT;
          else begin
            ord_ra = AW'(cand_q - CW'(1)); state_d = ST_INS_CMP;
          end
        end else begin
          i_d = i_q + CW'(1); state_d = ST_FILT_RD;
        end
      end
      ST_INS_CMP: begin
        // entry j-1 in ord_rd; strictly lower score moves up, ties stay ahead
        if (ord_rd[OW-1 -: ScoreBits] < cur_score_q) begin
          ord_we = 1'b1; ord_wa = j_q[AW-1:0]; ord_wd = ord_rd;
          j_d = j_q - CW'(1);
          if (j_q == CW'(1)) state_d = ST_INS_PUT;
          else ord_ra = AW'(j_q - CW'(2));
        end else state_d = ST_INS_PUT;
      end
      ST_INS_PUT: begin
        ord_we = 1'b1; ord_wa = j_q[AW-1:0]; ord_wd = {cur_score_q, cur_idx_q};
        cand_d = cand_q + CW'(1); i_d = i_q + CW'(1); state_d = ST_FILT_RD;
      end
      ST_TRIM: begin
        if (keep_top_q != '0 && 32'(keep_top_q) < 32'(cand_q)) cand_d = CW'(keep_top_q);
        cur_thr_d = ovl_thr_q; kept_d = '0; i_d = '0; state_d = ST_CAND_RD;
      end
      ST_CAND_RD: begin
        if (i_q >= cand_q || kept_q == KW'(ResultCap)) begin
          k_d = '0; state_d = ST_EMIT_RD;
        end else begin
          ord_ra = i_q[AW-1:0]; state_d = ST_CAND_BOX;
        end
      end
      ST_CAND_BOX: begin
        box_ra = ord_rd[AW-1:0]; cur_idx_d = ord_rd[AW-1:0]; j_d = '0;
        state_d = ST_IOU_RD;
      end
      ST_IOU_RD: begin
        // box_rd holds the candidate box on the first visit
        if (j_q == '0) cand_box_ld = 1'b1;
        if (KW'(j_q) == kept_q) begin
          kept_we = 1'b1; kept_d = kept_q + KW'(1);
          if (decay_q < OneQ16 && cur_thr_q > HalfQ16) cur_thr_d = dec_prod[31:16];
          i_d = i_q + CW'(1); state_d = ST_CAND_RD;
        end else begin
          kept_ra = (KW-1)'(j_q); state_d = ST_IOU_BOX;
        end
      end
      ST_IOU_BOX: begin
        box_ra = kept_rd; state_d = ST_IOU_A;
      end
      ST_IOU_A: begin
        state_d = ST_IOU_B;
      end
      ST_IOU_B: begin
        state_d = ST_IOU_C;
      end
      ST_IOU_C: begin
        if (suppress) begin
          i_d = i_q + CW'(1); state_d = ST_CAND_RD;
        end else begin
          j_d = j_q + CW'(1); state_d = ST_IOU_RD;
        end
      end
      ST_EMIT_RD: begin
        if (kept_q == '0) begin
          if (!res_valid_q || res_out.ready) begin
            res_valid_d = 1'b1;
            res_d = '{keep_idx: '0, none_kept: 1'b1, dropped_overflow: ovf_q,
                      result_last: 1'b1};
            state_d = ST_LOAD; cnt_d = '0; ovf_d = 1'b0;
          end
        end else begin
          kept_ra = (KW-1)'(k_q); state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // keep re-reading the same entry while the output is blocked
        kept_ra = (KW-1)'(k_q);
        if (!res_valid_q || res_out.ready) begin
          res_valid_d = 1'b1;
          res_d = '{keep_idx: IdxBits'(kept_rd), none_kept: 1'b0,
                    dropped_overflow: ovf_q, result_last: (k_q + KW'(1) == kept_q)};
          k_d = k_q + KW'(1);
          if (k_q + KW'(1) == kept_q) begin
            state_d = ST_LOAD; cnt_d = '0; ovf_d = 1'b0;
          end else state_d = ST_EMIT_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; cnt_q <= '0; i_q <= '0; j_q <= '0; cand_q <= '0;
      kept_q <= '0; k_q <= '0; ovf_q <= 1'b0; cur_thr_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; i_q <= i_d; j_q <= j_d; cand_q <= cand_d;
      kept_q <= kept_d; k_q <= k_d; ovf_q <= ovf_d; cur_thr_q <= cur_thr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d; cur_score_q <= cur_score_d; cur_idx_q <= cur_idx_d;
  end

`ifndef SYNTHESIS
  a_no_load_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> !box_in.ready) else $error("box accepted during run");
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_BOXES)) else $error("box count past capacity");
  a_kept_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= KW'(ResultCap)) else $error("kept count past cap");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_out.valid && !res_out.ready) |=> res_out.valid) else $error("result lost");
  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_out.valid && !res_out.ready) |=> $stable(res_q)) else $error("result changed");
`endif
endmodule

/* tb/sv/tb_box_non_maximum_suppression_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_non_maximum_suppression_top
// Self-checking bench: loads scored box sets, predicts the kept indices with a
// behavioural NMS model and checks every result transaction in order.
// ----------------------------------------------------------------------------
module tb_box_non_maximum_suppression_top;
  import bnms_pkg::*;

  localparam int MaxBoxes   = 64;
  localparam longint Limit  = 3000000;

  typedef struct packed {
    logic signed [CoordBits-1:0] left;
    logic signed [CoordBits-1:0] top;
    logic [DimBits-1:0]          width;
    logic [DimBits-1:0]          height;
    logic [ScoreBits-1:0]        score;
    logic                        last;
  } box_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bnms_box_if box_in();
  bnms_cfg_if cfg_in();
  bnms_res_if res_out();

  box_non_maximum_suppression_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .box_in (box_in.sink),
    .cfg_in (cfg_in.sink),
    .res_out(res_out.source)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [15:0] score_thr = 16'd0;
  logic [15:0] overlap_thr = 16'd29491;
  logic [16:0] decay = 17'd65536;
  logic [6:0]  keep_top = 7'd0;
  box_t        set_boxes[MaxBoxes];
  int          set_count = 0;
  bit          set_overflow = 1'b0;

  box_t    pending_boxes[$];
  result_t expected_results[$];
  int      errors = 0;
  longint  cycle_count = 0;
  bit      stim_done = 1'b0;
  bit      hold_arm = 1'b0;
  bit      hold_used = 1'b0;
  int      hold_off = 0;

  function automatic bit too_much_overlap(box_t a, box_t b, logic [15:0] thr);
    longint l, t, r, btm, iw, ih, inter, uni;
    l = (a.left > b.left) ? a.left : b.left;
    t = (a.top > b.top) ? a.top : b.top;
    r = ((longint'(a.left) + longint'(a.width)) < (longint'(b.left) + longint'(b.width))) ?
        longint'(a.left) + longint'(a.width) : longint'(b.left) + longint'(b.width);
    btm = ((longint'(a.top) + longint'(a.height)) < (longint'(b.top) + longint'(b.height))) ?
          longint'(a.top) + longint'(a.height) : longint'(b.top) + longint'(b.height);
    iw = (r - l > 0) ? r - l : 0;
    ih = (btm - t > 0) ? btm - t : 0;
    inter = iw * ih;
    if (inter <= 0) return 1'b0;
    uni = longint'(a.width) * longint'(a.height) + longint'(b.width) * longint'(b.height)
          - inter;
    if (uni <= 0) return 1'b0;
    return (inter << 16) > longint'(thr) * uni;
  endfunction

  // runs score filtering, sorting and greedy suppression over the collected set and queues the expected results
  task automatic predict_kept_boxes();
    int order[$];
    int kept[$];
    int j, ncand;
    logic [15:0] thr;
    bit keep;
    result_t r;
    for (int i = 0; i < set_count; i++) begin
      if (set_boxes[i].score > score_thr) begin
        j = order.size();
        while (j > 0 && set_boxes[order[j-1]].score < set_boxes[i].score) j--;
        order.insert(j, i);
      end
    end
    ncand = order.size();
    if (keep_top > 0 && keep_top < ncand) ncand = keep_top;
    thr = overlap_thr;
    for (int i = 0; i < ncand && kept.size() < ResultCap; i++) begin
      keep = 1'b1;
      foreach (kept[k])
        if (too_much_overlap(set_boxes[order[i]], set_boxes[kept[k]], thr)) keep = 1'b0;
      if (keep) begin
        kept.insert(kept.size(), order[i]);
        if (decay < OneQ16 && thr > HalfQ16) thr = 16'((longint'(thr) * decay) >> 16);
      end
    end
    if (kept.size() == 0) begin
      r = '{keep_idx: '0, none_kept: 1'b1, dropped_overflow: set_overflow,
            result_last: 1'b1};
      expected_results.insert(expected_results.size(), r);
    end
    foreach (kept[k]) begin
      r = '{keep_idx: IdxBits'(kept[k]), none_kept: 1'b0,
            dropped_overflow: set_overflow, result_last: (k == kept.size() - 1)};
      expected_results.insert(expected_results.size(), r);
    end
    set_count = 0;
    set_overflow = 1'b0;
  endtask

  // driver: bursts with random gaps
  int gap = 0;
  int burst = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_in.valid <= 1'b0;
      {box_in.box_left, box_in.box_top, box_in.box_width, box_in.box_height,
       box_in.box_score, box_in.box_last} <= '0;
    end else begin
      if (box_in.valid && box_in.ready) begin
        if (set_count < MaxBoxes) begin
          set_boxes[set_count] = '{box_in.box_left, box_in.box_top, box_in.box_width,
                                   box_in.box_height, box_in.box_score, box_in.box_last};
          set_count++;
        end else begin
          set_overflow = 1'b1;
        end
        if (box_in.box_last) predict_kept_boxes();
      end
      if (!box_in.valid || box_in.ready) begin
        if (gap > 0) begin
          gap--;
          box_in.valid <= 1'b0;
        end else if (pending_boxes.size() > 0) begin
          box_t b;
          b = pending_boxes.pop_front();
          box_in.valid <= 1'b1;
          {box_in.box_left, box_in.box_top, box_in.box_width, box_in.box_height,
           box_in.box_score, box_in.box_last} <= b;
          if (burst > 0) burst--;
          else begin
            burst = $urandom_range(12, 0);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(4, 1);
          end
        end else begin
          box_in.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_out.ready <= 1'b0;
    end else begin
      cycle_count++;
      if (res_out.valid && res_out.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result keep_idx=%0d", res_out.keep_idx);
          errors++;
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (res_out.none_kept !== e.none_kept) begin
            $error("none_kept exp %0d got %0d", e.none_kept, res_out.none_kept);
            errors++;
          end
          if (!e.none_kept && res_out.keep_idx !== e.keep_idx) begin
            $error("keep_idx exp %0d got %0d", e.keep_idx, res_out.keep_idx);
            errors++;
          end
          if (res_out.dropped_overflow !== e.dropped_overflow) begin
            $error("dropped_overflow exp %0d got %0d", e.dropped_overflow,
                   res_out.dropped_overflow);
            errors++;
          end
          if (res_out.result_last !== e.result_last) begin
            $error("result_last exp %0d got %0d", e.result_last, res_out.result_last);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        res_out.ready <= 1'b0;
      end else if (hold_arm && !hold_used && res_out.valid) begin
        // long stall while the next set is already being offered
        hold_used = 1'b1;
        hold_off = 400;
        res_out.ready <= 1'b0;
      end else if ((cycle_count % 97) < 40) begin
        res_out.ready <= 1'b1;
      end else begin
        res_out.ready <= ($urandom_range(3, 0) != 0);
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [16:0] value);
    @(posedge clk_i);
    cfg_in.valid <= 1'b1;
    cfg_in.index <= idx;
    cfg_in.data  <= value;
    do @(posedge clk_i); while (!cfg_in.ready);
    cfg_in.valid <= 1'b0;
    case (idx)
      CFG_SCORE_THR:   score_thr = value[15:0];
      CFG_OVERLAP_THR: overlap_thr = value[15:0];
      CFG_DECAY:       decay = value;
      default:         keep_top = value[6:0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_boxes.size() > 0 || box_in.valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic add_box(box_t b);
    pending_boxes.insert(pending_boxes.size(), b);
  endtask

  function automatic box_t rand_box(bit clustered, bit is_last);
    box_t b;
    if (clustered) begin
      b.left = CoordBits'($urandom_range(140, 100)) - 14'sd120;
      b.top = CoordBits'($urandom_range(140, 100)) - 14'sd120;
      b.width = DimBits'($urandom_range(60, 20));
      b.height = DimBits'($urandom_range(60, 20));
    end else begin
      b.left = CoordBits'($urandom);
      b.top = CoordBits'($urandom);
      b.width = ($urandom_range(3, 0) == 0) ? DimBits'($urandom) : DimBits'($urandom_range(200));
      b.height = ($urandom_range(3, 0) == 0) ? DimBits'($urandom) : DimBits'($urandom_range(200));
    end
    b.score = ($urandom_range(4, 0) == 0) ? 16'($urandom_range(3, 0) * 16384) : 16'($urandom);
    b.last = is_last;
    return b;
  endfunction

  task automatic queue_set(int n, bit clustered);
    for (int i = 0; i < n; i++) add_box(rand_box(clustered, i == n - 1));
  endtask

  initial begin
    cfg_in.valid = 1'b0;
    cfg_in.index = CFG_SCORE_THR;
    cfg_in.data = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, identical boxes, ties, zero area
    add_box('{-14'sd8192, -14'sd8192, 13'd8191, 13'd8191, 16'hFFFF, 1'b0});
    add_box('{14'sd8191, 14'sd8191, 13'd8191, 13'd8191, 16'hFFFF, 1'b0});
    add_box('{14'sd0, 14'sd0, 13'd0, 13'd10, 16'd100, 1'b0});
    add_box('{14'sd0, 14'sd0, 13'd50, 13'd50, 16'd200, 1'b0});
    add_box('{14'sd0, 14'sd0, 13'd50, 13'd50, 16'd200, 1'b0});
    add_box('{14'sd5, 14'sd5, 13'd50, 13'd50, 16'd0, 1'b1});
    add_box('{14'sd1, 14'sd1, 13'd4, 13'd4, 16'd0, 1'b1}); // nothing kept
    wait_drained();
    write_reg(CFG_SCORE_THR, 17'd65535);
    add_box('{14'sd1, 14'sd1, 13'd4, 13'd4, 16'hFFFF, 1'b1});
    wait_drained();
    write_reg(CFG_SCORE_THR, 17'd0);
    // overflow set, then a second set offered while the receiver holds off
    hold_arm = 1'b1;
    queue_set(70, 1'b0);
    queue_set(8, 1'b1);
    wait_drained();

    write_reg(CFG_OVERLAP_THR, 17'd0);
    write_reg(CFG_DECAY, 17'd0);
    write_reg(CFG_KEEP_TOP, 17'd64);
    queue_set(12, 1'b1);
    wait_drained();
    write_reg(CFG_OVERLAP_THR, 17'd65535);
    write_reg(CFG_DECAY, 17'd1);
    write_reg(CFG_KEEP_TOP, 17'd1);
    queue_set(8, 1'b1);
    wait_drained();
    write_reg(CFG_OVERLAP_THR, 17'd52000);
    write_reg(CFG_DECAY, 17'd50000);
    write_reg(CFG_KEEP_TOP, 17'd5);
    write_reg(CFG_SCORE_THR, 17'd20000);
    for (int s = 0; s < 6; s++) queue_set($urandom_range(10, 1), $urandom_range(1, 0));
    wait_drained();
    write_reg(CFG_OVERLAP_THR, 17'd29491);
    write_reg(CFG_DECAY, 17'd65536);
    write_reg(CFG_KEEP_TOP, 17'd0);
    write_reg(CFG_SCORE_THR, 17'd0);
    for (int s = 0; s < 5; s++) queue_set($urandom_range(12, 1), $urandom_range(1, 0));
    wait_drained();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done == 1'b1 || cycle_count >= Limit);
    if (!stim_done) begin
      $display("Simulation FAILED");
    end else if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
